// ===== rtl/tedd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tedd_pkg;

    localparam int GRAY_W     = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int STAB_W     = 10;
    localparam int ERR_W      = 24;
    localparam int ACC_W      = 28;
    localparam int ROW_W      = 10;
    localparam int MAX_HEIGHT = 1024;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_STABILITY    = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0]  WIDTH_RESET     = 11'd512;
    localparam logic [CFG_W-1:0]  HEIGHT_RESET    = 11'd342;
    localparam logic [STAB_W-1:0] STABILITY_RESET = 10'd0;

    localparam acc_t FULL_WHITE = 28'sd65280;
    localparam acc_t HALF_SCALE = 28'sd32640;
    localparam acc_t ACC_ZERO   = 28'sd0;
    localparam acc_t SAT_MAX    = 28'sd8388607;
    localparam acc_t SAT_MIN    = -28'sd8388608;

    // pixel held between the input register and the result register
    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              prev_dot;
        logic              last_col;
        logic              last_row;
        logic              row_nz;
    } pix_ctl_t;

    function automatic err_t sat24(input acc_t v);
        err_t r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[ERR_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[ERR_W-1:0];
        end
        else
        begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tedd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tedd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/temporal_error_diffusion_dither_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Floyd-Steinberg dither (7,3,5,1 over 16) of 8-bit gray pixels in raster order, with the
// threshold pulled toward the dot the previous frame had at the same position by
// stability_q8 (0 gives plain error diffusion). One pixel per clock is sustained while
// dot_ready holds; the line buffer is read and the input register loaded at the pixel
// transfer, and the diffusion step then loads the result register. The single write port of
// the line buffer is the limit: in the corner case of a one-pixel row following a longer
// one, a pixel may wait for the deferred write. After reset the line buffer is cleared entry
// by entry, during which pixel_ready stays low; configuration writes are taken at any time
// but must only be issued while no pixel is in flight.

module temporal_error_diffusion_dither_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [tedd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tedd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           pixel_valid,
    output logic                                pixel_ready,
    input  wire logic [tedd_pkg::GRAY_W-1:0]    gray,
    input  wire logic                           previous_dot,
    output logic                                dot_valid,
    input  wire logic                           dot_ready,
    output logic                                dot,
    output logic                                end_of_row,
    output logic                                end_of_frame
);

    import tedd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [CW-1:0]    LAST_COL = CW'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_HEIGHT - 1);

    // configuration
    logic [CFG_W-1:0]  image_width_reg;
    logic [CFG_W-1:0]  image_height_reg;
    logic [STAB_W-1:0] stability_reg;

    // position and input stage
    logic [CW-1:0]    column_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PW-1:0]    col_plus1;
    logic [CFG_W-1:0] row_plus1;
    logic             last_col_in;
    logic             last_row_in;
    logic             pixel_accept;

    logic             a_valid_reg;
    pix_ctl_t         stg_reg;
    logic [CW-1:0]    col_a_reg;
    logic             fwd_hit_reg;
    err_t             fwd_data_reg;
    logic             fwd_hit_next;
    err_t             fwd_data_next;
    logic             a_fire;

    // diffusion state
    err_t right_carry_reg;
    err_t below_pending_reg;
    err_t below_right_pending_reg;

    // deferred second line buffer write at the end of a row
    logic          dw_valid_reg;
    logic [CW-1:0] dw_addr_reg;
    err_t          dw_data_reg;

    // clearing pass
    logic          clearing_reg;
    logic [CW-1:0] clear_addr_reg;

    // line buffer port
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    err_t          ram_wdata;
    logic [ERR_W-1:0] ram_rdata;

    // output register
    logic dot_valid_reg;
    logic dot_reg;
    logic end_of_row_reg;
    logic end_of_frame_reg;

    // datapath
    err_t                below;
    acc_t                sum;
    err_t                v;
    logic [STAB_W+7:0]   stab_x255;
    logic [STAB_W+6:0]   offset;
    acc_t                thr;
    logic                dot_c;
    acc_t                err;
    acc_t                s7;
    acc_t                s3;
    acc_t                s5;
    acc_t                s1;
    err_t                rc_c;
    err_t                bp_e1;
    err_t                brp_e2;
    err_t                e3_c;
    logic                fire_we_want;
    logic                queue_tail;
    logic [CW-1:0]       fire_waddr;
    err_t                fire_wdata;

    always_comb
    begin
        col_plus1   = PW'(column_reg) + PW'(1);
        row_plus1   = CFG_W'(row_reg) + CFG_W'(1);
        last_col_in = (col_plus1 >= PW'(image_width_reg)) || (column_reg == LAST_COL);
        last_row_in = (row_plus1 >= image_height_reg) || (row_reg == LAST_ROW);
    end

    // ---------------------------------------------------------------- diffusion step
    always_comb
    begin
        below = stg_reg.row_nz ? (fwd_hit_reg ? fwd_data_reg : err_t'(ram_rdata)) : '0;
        sum   = acc_t'({{(ACC_W-GRAY_W-8){1'b0}}, stg_reg.gray, 8'h00})
              + acc_t'(right_carry_reg) + acc_t'(below);
        v     = sat24(sum);

        stab_x255 = {stability_reg, 8'h00} - (STAB_W+8)'(stability_reg);
        offset    = stab_x255[STAB_W+7:1];
        thr       = stg_reg.prev_dot ? (HALF_SCALE - acc_t'(offset))
                                     : (HALF_SCALE + acc_t'(offset));
        dot_c     = acc_t'(v) > thr;
        err       = acc_t'(v) - (dot_c ? FULL_WHITE : ACC_ZERO);

        // floor shares: weight products shifted arithmetically by 4
        s7 = ((err <<< 3) - err) >>> 4;
        s3 = ((err <<< 1) + err) >>> 4;
        s5 = ((err <<< 2) + err) >>> 4;
        s1 = err >>> 4;

        rc_c   = stg_reg.last_col ? '0 : sat24(s7);
        bp_e1  = sat24(acc_t'(below_pending_reg) + s3);
        brp_e2 = sat24(acc_t'(below_right_pending_reg) + s5);
        e3_c   = sat24(s1);

        // at the last column of a longer row two entries are due: col-1 now, col through the deferred write
        fire_we_want = a_valid_reg && !stg_reg.last_row
                     && ((col_a_reg != '0) || stg_reg.last_col);
        queue_tail   = !stg_reg.last_row && stg_reg.last_col && (col_a_reg != '0);
        if (stg_reg.last_col && (col_a_reg == '0))
        begin
            fire_waddr = col_a_reg;
            fire_wdata = brp_e2;
        end
        else
        begin
            fire_waddr = col_a_reg - CW'(1);
            fire_wdata = bp_e1;
        end

        a_fire = a_valid_reg && (!dot_valid_reg || dot_ready)
               && !(dw_valid_reg && fire_we_want);
        pixel_ready  = !clearing_reg && (!a_valid_reg || a_fire);
        pixel_accept = pixel_valid && pixel_ready;
    end

    // ---------------------------------------------------------------- line buffer port
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end
        else if (dw_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = dw_addr_reg;
            ram_wdata = dw_data_reg;
        end
        else
        begin
            ram_we    = a_fire && fire_we_want;
            ram_waddr = fire_waddr;
            ram_wdata = fire_wdata;
        end

        // a read at the same edge as a write (or a queued tail write) to that entry
        if (a_fire && queue_tail && (col_a_reg == column_reg))
        begin
            fwd_hit_next  = 1'b1;
            fwd_data_next = brp_e2;
        end
        else
        begin
            fwd_hit_next  = ram_we && (ram_waddr == column_reg);
            fwd_data_next = ram_wdata;
        end
    end

    tedd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pixel_accept),
        .raddr (column_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg         <= WIDTH_RESET;
            image_height_reg        <= HEIGHT_RESET;
            stability_reg           <= STABILITY_RESET;
            column_reg              <= '0;
            row_reg                 <= '0;
            a_valid_reg             <= 1'b0;
            dot_valid_reg           <= 1'b0;
            right_carry_reg         <= '0;
            below_pending_reg       <= '0;
            below_right_pending_reg <= '0;
            dw_valid_reg            <= 1'b0;
            clearing_reg            <= 1'b1;
            clear_addr_reg          <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    REG_STABILITY:    stability_reg    <= cfg_data[STAB_W-1:0];
                    default:          ;
                endcase
            end

            if (clearing_reg)
            begin
                clear_addr_reg <= clear_addr_reg + CW'(1);
                if (clear_addr_reg == LAST_COL)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (pixel_accept)
            begin
                a_valid_reg <= 1'b1;
                if (last_col_in)
                begin
                    column_reg <= '0;
                    row_reg    <= last_row_in ? '0 : row_plus1[ROW_W-1:0];
                end
                else
                begin
                    column_reg <= col_plus1[CW-1:0];
                end
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_fire)
            begin
                dot_valid_reg   <= 1'b1;
                right_carry_reg <= rc_c;
                if (!stg_reg.last_row && !stg_reg.last_col)
                begin
                    below_pending_reg       <= brp_e2;
                    below_right_pending_reg <= e3_c;
                end
                else
                begin
                    below_pending_reg       <= '0;
                    below_right_pending_reg <= '0;
                end
            end
            else if (dot_ready)
            begin
                dot_valid_reg <= 1'b0;
            end

            if (a_fire && queue_tail)
            begin
                dw_valid_reg <= 1'b1;
            end
            else if (!clearing_reg)
            begin
                dw_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            stg_reg.gray     <= gray;
            stg_reg.prev_dot <= previous_dot;
            stg_reg.last_col <= last_col_in;
            stg_reg.last_row <= last_row_in;
            stg_reg.row_nz   <= row_reg != '0;
            col_a_reg        <= column_reg;
            fwd_hit_reg      <= fwd_hit_next;
            fwd_data_reg     <= fwd_data_next;
        end
        if (a_fire)
        begin
            dot_reg          <= dot_c;
            end_of_row_reg   <= stg_reg.last_col;
            end_of_frame_reg <= stg_reg.last_col && stg_reg.last_row;
        end
        if (a_fire && queue_tail)
        begin
            dw_addr_reg <= col_a_reg;
            dw_data_reg <= brp_e2;
        end
    end

    assign dot_valid    = dot_valid_reg;
    assign dot          = dot_reg;
    assign end_of_row   = end_of_row_reg;
    assign end_of_frame = end_of_frame_reg;

endmodule

`default_nettype wire

// ===== tb/temporal_error_diffusion_dither_core_tb.sv =====
`timescale 1ns / 1ps

module temporal_error_diffusion_dither_core_tb;

    localparam int          LINE_LEN       = 1024;
    localparam int          ROWS_MAX       = tedd_pkg::MAX_HEIGHT;
    localparam longint      PIX_WHITE      = 65280;
    localparam longint      PIX_HALF       = 32640;
    localparam longint      ERR_HI         = 8388607;
    localparam longint      ERR_LO         = -8388608;
    localparam logic [1:0]  REG_SPARE      = 2'd3;    // not a register, write is dropped
    localparam int          IDLE_HEAVY_PCT = 52;
    localparam int          IDLE_BOTH_PCT  = 20;
    localparam int          DRAIN_SETTLE   = 4;
    localparam int          TAIL_CYCLES    = 16;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_PIXELS  = 600;
    localparam int          WIDE_PHASE     = 5;
    localparam int          WIDE_EXTRA     = 8;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_WRITE,
        OP_DRAIN,
        OP_MODE
    } op_kind_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic [1:0] {
        STREAM_UNIFORM,
        STREAM_EXTREMES,
        STREAM_MIDTONE,
        STREAM_FLAT
    } stream_style_t;

    typedef struct {
        op_kind_t                          kind;
        logic [tedd_pkg::GRAY_W-1:0]       gray;
        logic                              prev;
        logic [tedd_pkg::CFG_IDX_W-1:0]    idx;
        logic [tedd_pkg::CFG_W-1:0]        val;
        idle_mode_t                        mode;
    } pending_op_t;

    typedef struct packed {
        logic dot;
        logic eor;
        logic eof;
    } dot_result_t;

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               cfg_write_en = 1'b0;
    logic [tedd_pkg::CFG_IDX_W-1:0]     cfg_index    = '0;
    logic [tedd_pkg::CFG_W-1:0]         cfg_data     = '0;
    logic                               pixel_valid  = 1'b0;
    logic                               pixel_ready;
    logic [tedd_pkg::GRAY_W-1:0]        gray         = '0;
    logic                               previous_dot = 1'b0;
    logic                               dot_valid;
    logic                               dot_ready    = 1'b0;
    logic                               dot;
    logic                               end_of_row;
    logic                               end_of_frame;

    pending_op_t   stim_q[$];
    dot_result_t   dots_expected[$];

    // predictor state
    tedd_pkg::err_t                 line_err[LINE_LEN];
    tedd_pkg::err_t                 carry_right;
    tedd_pkg::err_t                 pend_below;
    tedd_pkg::err_t                 pend_below_right;
    int unsigned                    col_pos;
    int unsigned                    row_pos;
    logic [tedd_pkg::CFG_W-1:0]     cfg_width;
    logic [tedd_pkg::CFG_W-1:0]     cfg_height;
    logic [tedd_pkg::STAB_W-1:0]    cfg_stab;

    logic  pix_taken = 1'b0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    settle_count   = 0;
    int    quiet_cycles   = 0;
    int    fails          = 0;
    int    pixels_in      = 0;
    int    dots_checked   = 0;
    int    writes_done    = 0;

    temporal_error_diffusion_dither_core #(
        .MAX_WIDTH(LINE_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .gray(gray),
        .previous_dot(previous_dot),
        .dot_valid(dot_valid),
        .dot_ready(dot_ready),
        .dot(dot),
        .end_of_row(end_of_row),
        .end_of_frame(end_of_frame)
    );

    always #5 clk = ~clk;

    function automatic tedd_pkg::err_t clamp24(input longint v);
        longint r;
        r = v;
        if (v > ERR_HI)
        begin
            r = ERR_HI;
        end
        else if (v < ERR_LO)
        begin
            r = ERR_LO;
        end
        return r[tedd_pkg::ERR_W-1:0];
    endfunction

    task automatic apply_write(input logic [tedd_pkg::CFG_IDX_W-1:0] idx,
                               input logic [tedd_pkg::CFG_W-1:0] val);
        case (idx)
            tedd_pkg::REG_IMAGE_WIDTH:  cfg_width  = val;
            tedd_pkg::REG_IMAGE_HEIGHT: cfg_height = val;
            tedd_pkg::REG_STABILITY:    cfg_stab   = val[tedd_pkg::STAB_W-1:0];
            default: ;
        endcase
    endtask

    // one raster step of the dither, pushes the dot it must produce
    task automatic diffuse_pixel(input logic [tedd_pkg::GRAY_W-1:0] g, input logic pd);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        logic         lc;
        logic         lr;
        logic         d;
        longint       below;
        longint       v;
        longint       off;
        longint       thr;
        longint       err;
        longint       s7;
        longint       s3;
        longint       s5;
        longint       s1;
        dot_result_t  res;
        w = (cfg_width == 0) ? 1 : cfg_width;
        h = (cfg_height == 0) ? 1 : cfg_height;
        if (w > LINE_LEN)
        begin
            w = LINE_LEN;
        end
        if (h > ROWS_MAX)
        begin
            h = ROWS_MAX;
        end
        c  = col_pos % LINE_LEN;
        lc = (c + 1 >= w);
        lr = (row_pos + 1 >= h);

        below = (row_pos != 0) ? longint'(line_err[c]) : 0;
        v     = clamp24(longint'(g) * 256 + longint'(carry_right) + below);
        off   = (longint'(cfg_stab) * 255) >>> 1;
        thr   = pd ? PIX_HALF - off : PIX_HALF + off;
        d     = (v > thr);
        err   = v - (d ? PIX_WHITE : 0);
        s7    = (err * 7) >>> 4;
        s3    = (err * 3) >>> 4;
        s5    = (err * 5) >>> 4;
        s1    = err >>> 4;

        carry_right = lc ? '0 : clamp24(s7);
        if (!lr)
        begin
            if (c > 0)
            begin
                line_err[c - 1] = clamp24(longint'(pend_below) + s3);
            end
            if (!lc)
            begin
                pend_below       = clamp24(longint'(pend_below_right) + s5);
                pend_below_right = clamp24(s1);
            end
            else
            begin
                line_err[c]      = clamp24(longint'(pend_below_right) + s5);
                pend_below       = '0;
                pend_below_right = '0;
            end
        end
        else
        begin
            pend_below       = '0;
            pend_below_right = '0;
        end

        if (lc)
        begin
            col_pos = 0;
            row_pos = lr ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = c + 1;
        end

        res.dot = d;
        res.eor = lc;
        res.eof = lc && lr;
        dots_expected.push_back(res);
    endtask

    task automatic check_dot();
        dot_result_t want;
        if (dots_expected.size() == 0)
        begin
            $error("dot transfer with no pixel pending");
            fails++;
        end
        else
        begin
            want = dots_expected.pop_front();
            dots_checked++;
            if (dot !== want.dot)
            begin
                $error("dot: expected %0b, actual %0b", want.dot, dot);
                fails++;
            end
            if (end_of_row !== want.eor)
            begin
                $error("end_of_row: expected %0b, actual %0b", want.eor, end_of_row);
                fails++;
            end
            if (end_of_frame !== want.eof)
            begin
                $error("end_of_frame: expected %0b, actual %0b", want.eof, end_of_frame);
                fails++;
            end
        end
    endtask

    // predictor and result check, both on the sampled pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
            begin
                apply_write(cfg_index, cfg_data);
                writes_done++;
            end
            if (pixel_valid && pixel_ready)
            begin
                diffuse_pixel(gray, previous_dot);
                pixels_in++;
            end
            if (dot_valid && dot_ready)
            begin
                check_dot();
            end
        end
        pix_taken <= rst_n && pixel_valid && pixel_ready;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (dot_valid && dot_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        pending_op_t op;
        logic        hold_valid;
        logic        write_now;
        hold_valid = pixel_valid && !pix_taken;
        write_now  = 1'b0;
        if (rst_n && !hold_valid && stim_q.size() != 0)
        begin
            op = stim_q[0];
            case (op.kind)
                OP_PIXEL:
                begin
                    if ($urandom_range(99) >= send_idle_pct)
                    begin
                        hold_valid    = 1'b1;
                        gray         <= op.gray;
                        previous_dot <= op.prev;
                        void'(stim_q.pop_front());
                    end
                end
                OP_WRITE:
                begin
                    write_now  = 1'b1;
                    cfg_index <= op.idx;
                    cfg_data  <= op.val;
                    void'(stim_q.pop_front());
                end
                OP_DRAIN:
                begin
                    // hold off until the block has nothing in flight
                    if (dots_expected.size() != 0)
                    begin
                        settle_count = 0;
                    end
                    else if (settle_count == DRAIN_SETTLE)
                    begin
                        settle_count = 0;
                        void'(stim_q.pop_front());
                    end
                    else
                    begin
                        settle_count++;
                    end
                end
                default:
                begin
                    send_idle_pct  = (op.mode == IDLE_SENDER) ? IDLE_HEAVY_PCT :
                                     (op.mode == IDLE_BOTH) ? IDLE_BOTH_PCT : 0;
                    recv_stall_pct = (op.mode == IDLE_RECEIVER) ? IDLE_HEAVY_PCT :
                                     (op.mode == IDLE_BOTH) ? IDLE_BOTH_PCT : 0;
                    void'(stim_q.pop_front());
                end
            endcase
        end
        pixel_valid  <= hold_valid;
        cfg_write_en <= write_now;
        dot_ready    <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic queue_pixel(input logic [tedd_pkg::GRAY_W-1:0] g, input logic p);
        pending_op_t op;
        op = '{OP_PIXEL, g, p, '0, '0, IDLE_NONE};
        stim_q.push_back(op);
    endtask

    task automatic queue_write(input logic [tedd_pkg::CFG_IDX_W-1:0] idx,
                               input logic [tedd_pkg::CFG_W-1:0] val);
        pending_op_t op;
        op = '{OP_WRITE, '0, 1'b0, idx, val, IDLE_NONE};
        stim_q.push_back(op);
    endtask

    task automatic queue_drain();
        pending_op_t op;
        op = '{OP_DRAIN, '0, 1'b0, '0, '0, IDLE_NONE};
        stim_q.push_back(op);
    endtask

    task automatic queue_mode(input idle_mode_t m);
        pending_op_t op;
        op = '{OP_MODE, '0, 1'b0, '0, '0, m};
        stim_q.push_back(op);
    endtask

    task automatic queue_stream(input int n);
        stream_style_t               style;
        logic [tedd_pkg::GRAY_W-1:0] level;
        logic [tedd_pkg::GRAY_W-1:0] g;
        logic                        pd;
        logic                        p;
        style = stream_style_t'($urandom_range(3));
        level = 8'($urandom_range(255));
        pd    = 1'($urandom_range(1));
        for (int i = 0; i < n; i++)
        begin
            case (style)
                STREAM_UNIFORM:
                begin
                    g = 8'($urandom_range(255));
                    p = 1'($urandom_range(1));
                end
                STREAM_EXTREMES:
                begin
                    g = $urandom_range(1) ? 8'd255 : 8'd0;
                    p = 1'($urandom_range(1));
                end
                STREAM_MIDTONE:
                begin
                    g = 8'($urandom_range(143, 112));
                    p = pd ^ i[0];
                end
                default:
                begin
                    g = level;
                    p = pd;
                end
            endcase
            queue_pixel(g, p);
        end
    endtask

    // mostly small extents, now and then degenerate or past the clamp
    function automatic logic [tedd_pkg::CFG_W-1:0] pick_extent(input int typical_max);
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            return 11'($urandom_range(typical_max, 2));
        end
        else if (r < 85)
        begin
            return 11'($urandom_range(typical_max * 3, typical_max + 1));
        end
        else if (r < 92)
        begin
            return 11'($urandom_range(1));
        end
        return 11'($urandom_range(2047, 1024));
    endfunction

    initial
    begin
        int                           phase;
        int                           random_pixels;
        int                           n;
        logic [tedd_pkg::STAB_W-1:0]  stab;

        foreach (line_err[i])
        begin
            line_err[i] = '0;
        end
        carry_right      = '0;
        pend_below       = '0;
        pend_below_right = '0;
        col_pos          = 0;
        row_pos          = 0;
        cfg_width        = tedd_pkg::WIDTH_RESET;
        cfg_height       = tedd_pkg::HEIGHT_RESET;
        cfg_stab         = tedd_pkg::STABILITY_RESET;

        // reset geometry, plain diffusion, gray extremes and midpoints
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b1);
        queue_pixel(8'd128, 1'b0);
        queue_pixel(8'd127, 1'b1);
        // zero extents act as one, stability past 512, bogus index
        queue_drain();
        queue_write(REG_SPARE, 11'h7FF);
        queue_write(tedd_pkg::REG_IMAGE_WIDTH, 11'd0);
        queue_write(tedd_pkg::REG_IMAGE_HEIGHT, 11'd0);
        queue_write(tedd_pkg::REG_STABILITY, 11'h3FF);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b1);
        queue_pixel(8'd170, 1'b1);
        // extents past the maximum clamp
        queue_drain();
        queue_write(tedd_pkg::REG_IMAGE_WIDTH, 11'h7FF);
        queue_write(tedd_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
        queue_write(tedd_pkg::REG_STABILITY, 11'd512);
        queue_pixel(8'd255, 1'b1);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd1, 1'b1);
        // narrow mid-row: current column already past the new last one
        queue_drain();
        queue_write(tedd_pkg::REG_IMAGE_WIDTH, 11'd3);
        queue_write(tedd_pkg::REG_IMAGE_HEIGHT, 11'd2);
        queue_write(tedd_pkg::REG_STABILITY, 11'd256);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b1);
        queue_pixel(8'd200, 1'b0);
        queue_pixel(8'd60, 1'b1);
        queue_pixel(8'd255, 1'b1);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd128, 1'b1);
        queue_pixel(8'd127, 1'b0);

        phase         = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            if (phase == WIDE_PHASE)
            begin
                // more than a full row's worth of pixels at maximum width, then shrink mid-row
                queue_drain();
                queue_write(tedd_pkg::REG_IMAGE_WIDTH, 11'd1024);
                queue_write(tedd_pkg::REG_IMAGE_HEIGHT, 11'd1024);
                queue_mode(IDLE_BOTH);
                queue_stream(LINE_LEN + WIDE_EXTRA);
                queue_drain();
                queue_write(tedd_pkg::REG_IMAGE_WIDTH, 11'd5);
                queue_write(tedd_pkg::REG_IMAGE_HEIGHT, 11'd2);
            end
            else if ($urandom_range(3) != 0)
            begin
                queue_drain();
                if ($urandom_range(3) != 0)
                begin
                    queue_write(tedd_pkg::REG_IMAGE_WIDTH, pick_extent(8));
                end
                if ($urandom_range(3) != 0)
                begin
                    queue_write(tedd_pkg::REG_IMAGE_HEIGHT, pick_extent(5));
                end
                if ($urandom_range(2) == 0)
                begin
                    case ($urandom_range(4))
                        0:       stab = 10'd0;
                        1:       stab = 10'd256;
                        2:       stab = 10'd512;
                        3:       stab = 10'd1023;
                        default: stab = 10'($urandom_range(1023));
                    endcase
                    queue_write(tedd_pkg::REG_STABILITY, {1'($urandom_range(1)), stab});
                end
                if ($urandom_range(15) == 0)
                begin
                    queue_write(REG_SPARE, 11'($urandom_range(2047)));
                end
            end
            queue_mode(idle_mode_t'(phase % 4));
            n = $urandom_range(60, 6);
            queue_stream(n);
            random_pixels += n;
            phase++;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || pixel_valid || dots_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d pixels in %0d phases, %0d dots checked, %0d register writes",
                 pixels_in, phase, dots_checked, writes_done);
        $display("extents 0..2047 incl. full-width row, stability 0..1023, all idle patterns");
        if (fails == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
